// ----- rtl/lprd_pkg.sv -----
`default_nettype none
package lprd_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_DATA       = 2'd0;
   localparam logic [1:0] CMD_CHUNK_END  = 2'd1;
   localparam logic [1:0] CMD_STREAM_END = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_RECORD    = 2'd0;
   localparam logic [1:0] KIND_BOUNDARY  = 2'd1;
   localparam logic [1:0] KIND_TRUNCATED = 2'd2;
   localparam logic [1:0] KIND_CLEAN_END = 2'd3;

   // framing constants
   localparam logic [31:0] SLACK_PER_RECORD     = 32'd64;
   localparam logic [31:0] BATCH_TARGET_DEFAULT = 32'd262144;
   localparam int          PREFIX_BYTES         = 4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] payload_offset;
      logic [31:0] payload_length;
      logic [39:0] batch_weight;
      logic [31:0] batch_end_offset;
      logic        last;
   } rsp_entry_type;

   // up to two results per accepted item
   typedef struct packed {
      logic          valid0;
      logic          valid1;
      rsp_entry_type entry0;
      rsp_entry_type entry1;
   } push_type;

endpackage
`default_nettype wire

// ----- rtl/lprd_req_if.sv -----
`default_nettype none
interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/lprd_rsp_if.sv -----
`default_nettype none
interface lprd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] payload_offset;
   logic [31:0] payload_length;
   logic [39:0] batch_weight;
   logic [31:0] batch_end_offset;
   logic        last;

   modport source (output valid, output kind, output payload_offset, output payload_length,
                   output batch_weight, output batch_end_offset, output last, input ready);
   modport sink (input valid, input kind, input payload_offset, input payload_length,
                 input batch_weight, input batch_end_offset, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/lprd_front.sv -----
`default_nettype none
module lprd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [31:0]        csr_write_data,
   lprd_req_if.sink                req_channel,
   input  wire logic               queue_ready,
   output lprd_pkg::push_type      push
);

   // framing state
   logic [2:0]  prefix_count_ff, prefix_count_in;
   logic [31:0] length_shift_ff, length_shift_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic [31:0] batch_position_ff, batch_position_in;
   logic [31:0] framed_end_ff, framed_end_in;
   logic [39:0] pending_weight_ff, pending_weight_in;
   logic        records_any_ff, records_any_in;
   logic        in_payload_ff, in_payload_in;
   logic [31:0] target_ff;

   logic        accept;
   logic [31:0] pos_inc;
   logic [31:0] shifted_byte;
   logic [31:0] length_new;
   logic [2:0]  prefix_new;
   logic [31:0] left_dec;
   logic [31:0] frame_len;
   logic        do_frame;
   logic [40:0] weight_sum;
   logic [39:0] weight_sat;
   logic        tail;
   lprd_pkg::rsp_entry_type frame_entry, boundary_entry, end_entry;

   assign req_channel.ready = queue_ready;
   assign accept = req_channel.valid & queue_ready;

   // batch target register, zero stands for the default
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= lprd_pkg::BATCH_TARGET_DEFAULT;
      end else if (csr_write_enable) begin
         target_ff <= (csr_write_data == 32'd0) ? lprd_pkg::BATCH_TARGET_DEFAULT
                                                : csr_write_data;
      end
   end

   // place the prefix byte in little-endian order
   always_comb begin
      case (prefix_count_ff[1:0])
         2'd0:    shifted_byte = {24'd0, req_channel.data_byte};
         2'd1:    shifted_byte = {16'd0, req_channel.data_byte, 8'd0};
         2'd2:    shifted_byte = {8'd0, req_channel.data_byte, 16'd0};
         default: shifted_byte = {req_channel.data_byte, 24'd0};
      endcase
   end

   assign pos_inc    = batch_position_ff + 32'd1;
   assign length_new = length_shift_ff | shifted_byte;
   assign prefix_new = prefix_count_ff + 3'd1;
   assign left_dec   = payload_left_ff - 32'd1;
   assign frame_len  = in_payload_ff ? length_shift_ff : length_new;

   // a record completes on its last payload byte or on an empty prefix
   always_comb begin
      if (in_payload_ff) begin
         do_frame = (left_dec == 32'd0);
      end else begin
         do_frame = (prefix_new >= 3'(lprd_pkg::PREFIX_BYTES)) && (length_new == 32'd0);
      end
   end

   // saturating weight of the batch
   assign weight_sum = {1'b0, pending_weight_ff} + {9'd0, frame_len}
                       + {9'd0, lprd_pkg::SLACK_PER_RECORD};
   assign weight_sat = weight_sum[40] ? {40{1'b1}} : weight_sum[39:0];

   assign tail = in_payload_ff | (prefix_count_ff != 3'd0);

   // result items the front may produce
   always_comb begin
      frame_entry                  = '0;
      frame_entry.kind             = lprd_pkg::KIND_RECORD;
      frame_entry.payload_offset   = pos_inc - frame_len;
      frame_entry.payload_length   = frame_len;
      frame_entry.last             = 1'b1;

      boundary_entry                  = '0;
      boundary_entry.kind             = lprd_pkg::KIND_BOUNDARY;
      boundary_entry.batch_weight     = pending_weight_ff;
      boundary_entry.batch_end_offset = framed_end_ff;
      boundary_entry.last             = 1'b1;

      end_entry      = '0;
      end_entry.kind = tail ? lprd_pkg::KIND_TRUNCATED : lprd_pkg::KIND_CLEAN_END;
      end_entry.last = 1'b1;
   end

   // classify the item and work out the next state
   always_comb begin
      prefix_count_in   = prefix_count_ff;
      length_shift_in   = length_shift_ff;
      payload_left_in   = payload_left_ff;
      batch_position_in = batch_position_ff;
      framed_end_in     = framed_end_ff;
      pending_weight_in = pending_weight_ff;
      records_any_in    = records_any_ff;
      in_payload_in     = in_payload_ff;
      push              = '0;

      if (accept) begin
         unique case (req_channel.command)
            lprd_pkg::CMD_DATA: begin
               batch_position_in = pos_inc;
               if (do_frame) begin
                  pending_weight_in = weight_sat;
                  records_any_in    = 1'b1;
                  framed_end_in     = pos_inc;
                  prefix_count_in   = 3'd0;
                  length_shift_in   = 32'd0;
                  payload_left_in   = 32'd0;
                  in_payload_in     = 1'b0;
                  push.valid0       = 1'b1;
                  push.entry0       = frame_entry;
               end else if (in_payload_ff) begin
                  payload_left_in = left_dec;
               end else begin
                  length_shift_in = length_new;
                  prefix_count_in = prefix_new;
                  if (prefix_new >= 3'(lprd_pkg::PREFIX_BYTES)) begin
                     in_payload_in   = 1'b1;
                     payload_left_in = length_new;
                  end
               end
            end
            lprd_pkg::CMD_CHUNK_END: begin
               if (pending_weight_ff >= {8'd0, target_ff}) begin
                  batch_position_in = batch_position_ff - framed_end_ff;
                  framed_end_in     = 32'd0;
                  pending_weight_in = 40'd0;
                  records_any_in    = 1'b0;
                  push.valid0       = 1'b1;
                  push.entry0       = boundary_entry;
               end
            end
            lprd_pkg::CMD_STREAM_END: begin
               prefix_count_in   = 3'd0;
               length_shift_in   = 32'd0;
               payload_left_in   = 32'd0;
               batch_position_in = 32'd0;
               framed_end_in     = 32'd0;
               pending_weight_in = 40'd0;
               records_any_in    = 1'b0;
               in_payload_in     = 1'b0;
               push.valid0       = 1'b1;
               if (records_any_ff) begin
                  push.entry0      = boundary_entry;
                  push.entry0.last = 1'b0;
                  push.valid1      = 1'b1;
                  push.entry1      = end_entry;
               end else begin
                  push.entry0 = end_entry;
               end
            end
            default: begin
               // unused command, ignored
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_count_ff   <= 3'd0;
         length_shift_ff   <= 32'd0;
         payload_left_ff   <= 32'd0;
         batch_position_ff <= 32'd0;
         framed_end_ff     <= 32'd0;
         pending_weight_ff <= 40'd0;
         records_any_ff    <= 1'b0;
         in_payload_ff     <= 1'b0;
      end else begin
         prefix_count_ff   <= prefix_count_in;
         length_shift_ff   <= length_shift_in;
         payload_left_ff   <= payload_left_in;
         batch_position_ff <= batch_position_in;
         framed_end_ff     <= framed_end_in;
         pending_weight_ff <= pending_weight_in;
         records_any_ff    <= records_any_in;
         in_payload_ff     <= in_payload_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lprd_queue.sv -----
`default_nettype none
module lprd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lprd_pkg::push_type push,
   output logic                    queue_ready,
   lprd_rsp_if.source              rsp_channel
);

   lprd_pkg::rsp_entry_type entries_ff [lprd_pkg::QUEUE_DEPTH];
   logic [lprd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lprd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lprd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [lprd_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
   logic [lprd_pkg::QUEUE_CNT_W-1:0] push_count;
   logic                             pop;
   lprd_pkg::rsp_entry_type          head;

   // room for the two results an item may bring
   assign queue_ready = (count_ff <= lprd_pkg::QUEUE_CNT_W'(lprd_pkg::QUEUE_DEPTH - 2));

   assign pop         = (count_ff != '0) & rsp_channel.ready;
   assign push_count  = lprd_pkg::QUEUE_CNT_W'(push.valid0)
                        + lprd_pkg::QUEUE_CNT_W'(push.valid1);
   assign wr_ptr_next = wr_ptr_ff + lprd_pkg::QUEUE_PTR_W'(1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + lprd_pkg::QUEUE_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + lprd_pkg::QUEUE_PTR_W'(pop);
      count_in  = count_ff + push_count - lprd_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entries_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.valid1) begin
         entries_ff[wr_ptr_next] <= push.entry1;
      end
   end

   // head of the queue drives the result channel
   assign head                         = entries_ff[rd_ptr_ff];
   assign rsp_channel.valid            = (count_ff != '0);
   assign rsp_channel.kind             = head.kind;
   assign rsp_channel.payload_offset   = head.payload_offset;
   assign rsp_channel.payload_length   = head.payload_length;
   assign rsp_channel.batch_weight     = head.batch_weight;
   assign rsp_channel.batch_end_offset = head.batch_end_offset;
   assign rsp_channel.last             = head.last;

endmodule
`default_nettype wire

// ----- rtl/length_prefixed_record_deframer_unit.sv -----
// Length-prefixed record deframer.
// req_channel carries one item per handshake: a record-region byte, a chunk
// end or a stream end. Records are a 4-byte little-endian length followed by
// that many payload bytes. rsp_channel returns a framed-record item when a
// record's last byte arrives, a batch boundary at a chunk end once the batch
// weight reaches the target, and at stream end a final boundary (if records
// are pending) plus a truncated or clean end item; last marks the final item
// caused by one request item.
// csr_write_enable/csr_write_data set the batch target (zero means 262144);
// write it only while the block is idle.
// Throughput: one request item per cycle while the queue has room for two
// results. A stream end that yields two items takes two result handshakes.
// Results are registered in the four-entry queue between the framing front
// end and the result port.
// Reset (synchronous, active high) clears framing state and the queue and
// restores the default target. When the receiver stalls, results wait in the
// queue and requests keep flowing until fewer than two entries are free.
`default_nettype none
module length_prefixed_record_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   lprd_req_if.sink         req_channel,
   lprd_rsp_if.source       rsp_channel
);

   lprd_pkg::push_type push;
   logic               queue_ready;

   // framing front end
   lprd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_channel),
      .queue_ready      (queue_ready),
      .push             (push)
   );

   // result queue and output port
   lprd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_ready (queue_ready),
      .rsp_channel (rsp_channel)
   );

endmodule
`default_nettype wire

// ----- verif/lprd_deframe_check_pkg.sv -----
package lprd_deframe_check_pkg;
   import lprd_pkg::*;

   // tracks the framing state of the stream and the results it must produce
   class deframe_checker;
      rsp_entry_type due_results[$];
      logic [31:0]   target_bytes;
      logic [2:0]    prefix_seen;
      logic [31:0]   rec_length;
      logic [31:0]   bytes_left;
      logic [31:0]   position;
      logic [31:0]   framed_end;
      logic [39:0]   weight;
      logic [31:0]   record_count;
      logic          in_payload;
      int            errors;
      int            checked;
      int            kind_seen[4];

      function new();
         target_bytes = BATCH_TARGET_DEFAULT;
         errors = 0;
         checked = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         prefix_seen = '0;
         rec_length = '0;
         bytes_left = '0;
         position = '0;
         framed_end = '0;
         weight = '0;
         record_count = '0;
         in_payload = 1'b0;
      endfunction

      function void set_target(logic [31:0] value);
         target_bytes = value;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      function void push_result(logic [1:0] kind, logic [31:0] offset, logic [31:0] length,
                                logic [39:0] batch_sum, logic [31:0] end_offset, logic last);
         rsp_entry_type e;
         e.kind = kind;
         e.payload_offset = offset;
         e.payload_length = length;
         e.batch_weight = batch_sum;
         e.batch_end_offset = end_offset;
         e.last = last;
         due_results.insert(due_results.size(), e);
      endfunction

      // record complete: add its weight, saturating at 40 bits
      function void close_record();
         logic [40:0] sum;
         sum = {1'b0, weight} + 41'(rec_length) + 41'(SLACK_PER_RECORD);
         weight = sum[40] ? '1 : sum[39:0];
         if (record_count != '1) record_count = record_count + 32'd1;
         framed_end = position;
         push_result(KIND_RECORD, position - rec_length, rec_length, '0, '0, 1'b1);
         prefix_seen = '0;
         rec_length = '0;
         bytes_left = '0;
         in_payload = 1'b0;
      endfunction

      // positions restart at the unframed tail
      function void emit_boundary(logic last);
         push_result(KIND_BOUNDARY, '0, '0, weight, framed_end, last);
         position = position - framed_end;
         framed_end = '0;
         weight = '0;
         record_count = '0;
      endfunction

      // one accepted request item
      function void frame_item(logic [1:0] command, logic [7:0] data_value);
         logic [31:0] limit;
         logic        tail;
         case (command)
            CMD_DATA: begin
               position = position + 32'd1;
               if (!in_payload) begin
                  rec_length = rec_length | (32'(data_value) << (8 * prefix_seen[1:0]));
                  prefix_seen = prefix_seen + 3'd1;
                  if (prefix_seen >= PREFIX_BYTES) begin
                     if (rec_length == 0) begin
                        close_record();
                     end else begin
                        in_payload = 1'b1;
                        bytes_left = rec_length;
                     end
                  end
               end else begin
                  bytes_left = bytes_left - 32'd1;
                  if (bytes_left == 0) close_record();
               end
            end
            CMD_CHUNK_END: begin
               limit = (target_bytes == 0) ? BATCH_TARGET_DEFAULT : target_bytes;
               if (weight >= {8'd0, limit}) emit_boundary(1'b1);
            end
            CMD_STREAM_END: begin
               tail = in_payload || (prefix_seen != 0);
               if (record_count != 0) emit_boundary(1'b0);
               push_result(tail ? KIND_TRUNCATED : KIND_CLEAN_END, '0, '0, '0, '0, 1'b1);
               clear_stream();
            end
            default: ;
         endcase
      endfunction

      function void match_field(string name, logic [39:0] want, logic [39:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // one accepted result item against the oldest expectation
      function void check_result(rsp_entry_type got);
         rsp_entry_type want;
         checked++;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d offset %0h length %0h",
                     $time, got.kind, got.payload_offset, got.payload_length);
            return;
         end
         want = due_results[0];
         due_results.delete(0);
         if (!$isunknown(got.kind)) kind_seen[got.kind]++;
         match_field("kind", 40'(want.kind), 40'(got.kind));
         match_field("payload_offset", 40'(want.payload_offset), 40'(got.payload_offset));
         match_field("payload_length", 40'(want.payload_length), 40'(got.payload_length));
         match_field("batch_weight", want.batch_weight, got.batch_weight);
         match_field("batch_end_offset", 40'(want.batch_end_offset),
                     40'(got.batch_end_offset));
         match_field("last", 40'(want.last), 40'(got.last));
      endfunction
   endclass

endpackage

// ----- verif/length_prefixed_record_deframer_unit_tb.sv -----
module length_prefixed_record_deframer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lprd_pkg::*;
   import lprd_deframe_check_pkg::*;

   // command value the block ignores
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 90;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   lprd_req_if req_channel ();
   lprd_rsp_if rsp_channel ();

   deframe_checker frame_check;
   int  items_sent;
   int  settings_used;
   int  stall_left;
   int  idle_cycles;
   bit  req_burst;
   bit  rsp_burst;

   length_prefixed_record_deframer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_channel),
      .rsp_channel      (rsp_channel)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly small records, a few larger ones
   function automatic int record_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 8);
      if (r < 90) return $urandom_range(9, 40);
      if (r < 99) return $urandom_range(41, 300);
      return $urandom_range(301, 600);
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_channel.ready <= 1'b0;
      end else begin
         rsp_channel.ready <= 1'b1;
         if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
         if (!rsp_burst && $urandom_range(0, 2) == 0) stall_left = idle_gap();
      end
   end

   // sample handshakes and register writes
   always @(posedge clock) begin
      rsp_entry_type seen;
      if (!reset) begin
         if (csr_write_enable) frame_check.set_target(csr_write_data);
         if (req_channel.valid && req_channel.ready)
            frame_check.frame_item(req_channel.command, req_channel.data_byte);
         if (rsp_channel.valid && rsp_channel.ready) begin
            seen.kind = rsp_channel.kind;
            seen.payload_offset = rsp_channel.payload_offset;
            seen.payload_length = rsp_channel.payload_length;
            seen.batch_weight = rsp_channel.batch_weight;
            seen.batch_end_offset = rsp_channel.batch_end_offset;
            seen.last = rsp_channel.last;
            frame_check.check_result(seen);
         end
      end
   end

   // watchdog on cycles with no handshake
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_channel.valid && req_channel.ready)
             || (rsp_channel.valid && rsp_channel.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               IDLE_LIMIT, frame_check.outstanding());
      $display("Test completed with failures");
      $finish;
   end

   // one request item; entered and left at a falling edge
   task automatic send_item(input logic [1:0] command, input logic [7:0] data_value);
      int gap;
      gap = req_burst ? 0 : idle_gap();
      if (gap > 0) begin
         req_channel.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_channel.valid <= 1'b1;
      req_channel.command <= command;
      req_channel.data_byte <= data_value;
      do @(posedge clock); while (!req_channel.ready);
      if (command != CMD_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // little-endian length prefix
   task automatic send_prefix(input logic [31:0] length);
      for (int i = 0; i < PREFIX_BYTES; i++) send_item(CMD_DATA, length[8*i +: 8]);
   endtask

   // hold off until every expected result is back and the block has settled
   task automatic wait_for_results();
      req_channel.valid <= 1'b0;
      while (frame_check.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_target(input logic [31:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // a record with random payload, chunk ends and noise mixed in; a broken one
   // stops short and ends the stream
   task automatic send_record(input int length, input bit broken);
      logic [31:0] len_bits;
      int          total;
      int          stop;
      len_bits = length;
      total = PREFIX_BYTES + length;
      stop = broken ? $urandom_range(1, total - 1) : total;
      for (int i = 0; i < stop; i++) begin
         if ($urandom_range(0, 15) == 0) send_item(CMD_CHUNK_END, 8'($urandom));
         if ($urandom_range(0, 39) == 0) send_item(CMD_UNUSED, 8'($urandom));
         send_item(CMD_DATA, (i < PREFIX_BYTES) ? len_bits[8*i +: 8] : 8'($urandom));
      end
      if (broken) send_item(CMD_STREAM_END, 8'($urandom));
   endtask

   task automatic run_random_phase(input int budget);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         req_burst = ($urandom_range(0, 7) == 0);
         if (pick < 78) begin
            send_record(record_length(), 1'b0);
         end else if (pick < 86) begin
            send_record(record_length(), 1'b1);
         end else if (pick < 93) begin
            send_item(CMD_CHUNK_END, 8'($urandom));
         end else if (pick < 96) begin
            send_item(CMD_STREAM_END, 8'($urandom));
         end else if (pick < 99) begin
            // random bytes as a bogus length, then end of stream
            repeat ($urandom_range(1, 6)) send_item(CMD_DATA, 8'($urandom));
            send_item(CMD_STREAM_END, 8'($urandom));
         end else begin
            wait_for_results();
         end
      end
      send_item(CMD_STREAM_END, 8'($urandom));
   endtask

   // stimulus
   initial begin
      logic [31:0] targets[6];
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_channel.valid = 1'b0;
      req_channel.command = CMD_DATA;
      req_channel.data_byte = '0;
      rsp_channel.ready = 1'b0;
      items_sent = 0;
      settings_used = 1;
      stall_left = 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      frame_check = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default target: zero-length record, ignored command, chunk end below target
      send_prefix(32'd0);
      send_item(CMD_UNUSED, 8'hFF);
      send_item(CMD_CHUNK_END, 8'h00);
      send_prefix(32'd1);
      send_item(CMD_DATA, 8'hFF);
      // pending records flushed ahead of a clean end
      send_item(CMD_STREAM_END, 8'h00);

      // smallest target: boundary with a partial prefix left behind
      write_target(32'd1);
      send_prefix(32'd1);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'h03);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_CHUNK_END, 8'hA5);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'h00);
      // truncated inside a payload
      send_item(CMD_STREAM_END, 8'h5A);

      // random phases over several targets, zero meaning the default
      targets[0] = 32'd0;
      targets[1] = 32'hFFFF_FFFF;
      targets[2] = 32'd1;
      targets[3] = SLACK_PER_RECORD;
      targets[4] = $urandom_range(65, 2000);
      targets[5] = $urandom_range(200, 5000);
      foreach (targets[p]) begin
         write_target(targets[p]);
         run_random_phase(PHASE_ITEMS);
      end

      // drain and let the block settle
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d request items under %0d target settings, %0d results checked",
               items_sent, settings_used, frame_check.checked);
      $display("records %0d, boundaries %0d, truncated ends %0d, clean ends %0d",
               frame_check.kind_seen[KIND_RECORD], frame_check.kind_seen[KIND_BOUNDARY],
               frame_check.kind_seen[KIND_TRUNCATED], frame_check.kind_seen[KIND_CLEAN_END]);
      if (frame_check.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
